### rtl/core/tnc_pkg.sv
// Package for the TTL name cache: word types, operation codes and constants.
// Used by every module under rtl/core; depends on nothing else.
`timescale 1ns / 1ps

package tnc_pkg;

  // Operation codes carried in the kind field of an input word.
  localparam logic [1:0] KIND_LOOKUP = 2'd0;
  localparam logic [1:0] KIND_STORE_ENTRY = 2'd1;
  localparam logic [1:0] KIND_STORE_ADDR = 2'd2;
  localparam logic [1:0] KIND_CLEAR = 2'd3;

  // Expiry value that pins an entry: it never expires and is never evicted.
  localparam logic [47:0] EXP_MAX = 48'hFFFF_FFFF_FFFF;

  // Time to live after reset, in milliseconds.
  localparam logic [31:0] TTL_RESET = 32'd300000;

  // One input word.
  typedef struct packed {
    logic [1:0]  kind;
    logic [63:0] name_key;
    logic [47:0] now_ms;
    logic [7:0]  new_count;
    logic [2:0]  addr_index;
    logic [63:0] addr_high;
    logic [63:0] addr_low;
    logic        addr_is_v6;
  } item_t;

  // One result word.
  typedef struct packed {
    logic        hit;
    logic [3:0]  slot;
    logic [3:0]  count_out;
    logic [63:0] out_high;
    logic [63:0] out_low;
    logic        out_is_v6;
    logic        last;
    logic [31:0] hit_total;
    logic [31:0] miss_total;
  } result_t;

  // Key and expiry of one cache entry.
  typedef struct packed {
    logic [63:0] key;
    logic [47:0] expiry;
  } entry_t;

  // One stored address.
  typedef struct packed {
    logic [63:0] high;
    logic [63:0] low;
    logic        is_v6;
  } addr_t;

  // Control from the sequencer to the scan unit.
  typedef struct packed {
    logic start;
    logic step;
    logic is_store;
  } scan_ctrl_t;

  // Status from the scan unit to the sequencer.
  typedef struct packed {
    logic found;
    logic exp_sel;
    logic live_sel;
  } scan_flags_t;

endpackage

### rtl/core/tnc_entry_ram.sv
// Entry table of the TTL name cache: key, expiry and count memory plus valid flags.
// Depends on tnc_pkg for the entry type.
`timescale 1ns / 1ps

module tnc_entry_ram #(
  parameter int ENTRIES = 16,
  parameter int CW = 4
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  rd_en,
  input  logic [(ENTRIES > 1 ? $clog2(ENTRIES) : 1)-1:0] rd_addr,
  output logic                                  rd_valid,
  output tnc_pkg::entry_t                       rd_entry,
  output logic [CW-1:0]                         rd_count,
  input  logic                                  wr_en,
  input  logic [(ENTRIES > 1 ? $clog2(ENTRIES) : 1)-1:0] wr_addr,
  input  tnc_pkg::entry_t                       wr_entry,
  input  logic [CW-1:0]                         wr_count,
  input  logic                                  clr_all
);

  tnc_pkg::entry_t   mem [ENTRIES];
  logic [CW-1:0]     count_mem [ENTRIES];
  logic [ENTRIES-1:0] valid;

  // Memory write and registered read.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_entry;
      count_mem[wr_addr] <= wr_count;
    end
    if (rd_en) begin
      rd_entry <= mem[rd_addr];
      rd_count <= count_mem[rd_addr];
    end
  end

  // Valid flags live in flip-flops so that reset and clear take effect at once.
  always_ff @(posedge clk) begin
    if (rst || clr_all) begin
      valid <= '0;
    end else if (wr_en) begin
      valid[wr_addr] <= 1'b1;
    end
  end

  // The valid flag is read alongside the memory so both refer to the same entry.
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_valid <= 1'b0;
    end else if (rd_en) begin
      rd_valid <= valid[rd_addr];
    end
  end

endmodule

### rtl/core/tnc_addr_ram.sv
// Address store of the TTL name cache: one row of addresses per entry.
// Depends on tnc_pkg for the address type.
`timescale 1ns / 1ps

module tnc_addr_ram #(
  parameter int DEPTH = 128
) (
  input  logic                                    clk,
  input  logic                                    rd_en,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output tnc_pkg::addr_t                          rd_data,
  input  logic                                    wr_en,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  tnc_pkg::addr_t                          wr_data
);

  tnc_pkg::addr_t mem [DEPTH];

  // Single write port and one registered read port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

### rtl/core/tnc_scan.sv
// Shared compare unit of the TTL name cache, stepped once per entry by the sequencer.
// Depends on tnc_pkg for the entry type and the control and status structs.
`timescale 1ns / 1ps

module tnc_scan #(
  parameter int SW = 4
) (
  input  logic                 clk,
  input  tnc_pkg::scan_ctrl_t  ctrl,
  input  logic [SW-1:0]        idx,
  input  logic                 ent_valid,
  input  tnc_pkg::entry_t      ent,
  input  logic [63:0]          key,
  input  logic [47:0]          now,
  output tnc_pkg::scan_flags_t flags,
  output logic [SW-1:0]        exp_idx,
  output logic [SW-1:0]        live_idx
);

  logic        exp_sel;
  logic [47:0] exp_best;
  logic        live_sel;
  logic [47:0] live_best;
  logic        is_live;
  logic        pinned;

  // Compares for the entry at hand.
  assign is_live = ent.expiry > now;
  assign pinned = ent.expiry == tnc_pkg::EXP_MAX;

  // A lookup stops on a live matching key; a store stops on the first empty slot.
  always_comb begin
    flags.found = ctrl.is_store ? !ent_valid : (ent_valid && is_live && ent.key == key);
    flags.exp_sel = exp_sel;
    flags.live_sel = live_sel;
  end

  // Running eviction candidates: earliest expired entry and earliest live entry.
  always_ff @(posedge clk) begin
    if (ctrl.start) begin
      exp_sel <= 1'b0;
      live_sel <= 1'b0;
      live_best <= tnc_pkg::EXP_MAX;
    end else if (ctrl.step && ctrl.is_store && ent_valid && !pinned) begin
      if (!is_live) begin
        if (!exp_sel || ent.expiry < exp_best) begin
          exp_sel <= 1'b1;
          exp_best <= ent.expiry;
          exp_idx <= idx;
        end
      end else if (ent.expiry < live_best) begin
        live_sel <= 1'b1;
        live_best <= ent.expiry;
        live_idx <= idx;
      end
    end
  end

endmodule

### rtl/core/ttl_name_cache.sv
// Top level of the TTL name cache: sequencer, counters, config register and output word.
// Depends on tnc_pkg, tnc_entry_ram, tnc_addr_ram and tnc_scan.
`timescale 1ns / 1ps

// The cache handles one input word at a time and holds item_stall high until
// its last result word is registered. A lookup or a store entry walks the
// entry table one entry per cycle through its single registered read port. A
// lookup hit then reads each stored address in S_AREQ and gives it in S_AOUT,
// waiting there while the result is stalled. A store entry writes the first
// empty slot in S_WRITE; with none it walks the whole table, picks a victim in
// S_PICK and writes it, or drops the word if no entry can be evicted. A store
// address reads the count in S_CREAD and writes in S_CADDR, and a clear goes
// straight to S_EMIT. Every word gives at least one result word, and a lookup
// hit gives one per stored address, or one if it has none, with last set on the
// final one. A finished result waits in an output register, so a new input
// word is taken while it is still stalled. The user must write the time to
// live through ttl_we and ttl_wdata only while idle; the block itself does
// not enforce it.
module ttl_name_cache #(
  parameter int ENTRIES = 16,
  parameter int MAX_ADDRS = 8
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  output logic              item_stall,
  input  tnc_pkg::item_t    item,
  output logic              result_valid,
  input  logic              result_stall,
  output tnc_pkg::result_t  result,
  input  logic              ttl_we,
  input  logic [31:0]       ttl_wdata
);

  localparam int SW = ENTRIES > 1 ? $clog2(ENTRIES) : 1;
  localparam int CW = $clog2(MAX_ADDRS + 1);
  localparam int ADEPTH = ENTRIES * MAX_ADDRS;
  localparam int AW = ADEPTH > 1 ? $clog2(ADEPTH) : 1;

  // Sequencer states.
  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_SCAN = 4'd1;
  localparam logic [3:0] S_PICK = 4'd2;
  localparam logic [3:0] S_WRITE = 4'd3;
  localparam logic [3:0] S_CREAD = 4'd4;
  localparam logic [3:0] S_CADDR = 4'd5;
  localparam logic [3:0] S_AREQ = 4'd6;
  localparam logic [3:0] S_AOUT = 4'd7;
  localparam logic [3:0] S_EMIT = 4'd8;

  logic [3:0]       state, state_next;
  tnc_pkg::item_t   cur;
  logic [SW:0]      issue_ptr, issue_ptr_next;
  logic             ev_go, ev_go_next;
  logic [SW-1:0]    ev_idx, ev_idx_next;
  logic [SW-1:0]    hit_slot, hit_slot_next;
  logic [CW-1:0]    hit_cnt, hit_cnt_next;
  logic [CW-1:0]    addr_k, addr_k_next;
  logic [SW-1:0]    pick_idx, pick_idx_next;
  logic             res_hit, res_hit_next;
  logic [SW-1:0]    res_slot, res_slot_next;
  logic [CW-1:0]    res_cnt, res_cnt_next;
  logic [SW-1:0]    current_slot, current_slot_next;
  logic             current_ok, current_ok_next;
  logic [31:0]      hit_counter, hit_counter_next;
  logic [31:0]      miss_counter, miss_counter_next;
  logic [31:0]      ttl_ms;
  logic             result_valid_next;
  tnc_pkg::result_t result_next;

  logic             accept;
  logic             out_free;
  logic             is_store;
  logic             done_last;
  logic [48:0]      exp_sum;
  logic [47:0]      new_expiry;
  logic [CW-1:0]    clip_count;
  logic             addr_ok;

  // Entry table ports.
  logic             ent_rd_en;
  logic [SW-1:0]    ent_rd_addr;
  logic             ent_rd_valid;
  tnc_pkg::entry_t  ent_rd_entry;
  logic [CW-1:0]    ent_rd_count;
  logic             ent_wr_en;
  tnc_pkg::entry_t  ent_wr_entry;
  logic             ent_clr;

  // Address store ports.
  logic             adr_rd_en;
  logic [AW-1:0]    adr_rd_addr;
  tnc_pkg::addr_t   adr_rd_data;
  logic             adr_wr_en;
  logic [AW-1:0]    adr_wr_addr;
  tnc_pkg::addr_t   adr_wr_data;

  // Scan unit ports.
  tnc_pkg::scan_ctrl_t  scan_ctrl;
  tnc_pkg::scan_flags_t scan_flags;
  logic [SW-1:0]        exp_idx;
  logic [SW-1:0]        live_idx;

  tnc_entry_ram #(
    .ENTRIES (ENTRIES),
    .CW      (CW)
  ) u_entry_ram (
    .clk      (clk),
    .rst      (rst),
    .rd_en    (ent_rd_en),
    .rd_addr  (ent_rd_addr),
    .rd_valid (ent_rd_valid),
    .rd_entry (ent_rd_entry),
    .rd_count (ent_rd_count),
    .wr_en    (ent_wr_en),
    .wr_addr  (pick_idx),
    .wr_entry (ent_wr_entry),
    .wr_count (clip_count),
    .clr_all  (ent_clr)
  );

  tnc_addr_ram #(
    .DEPTH (ADEPTH)
  ) u_addr_ram (
    .clk     (clk),
    .rd_en   (adr_rd_en),
    .rd_addr (adr_rd_addr),
    .rd_data (adr_rd_data),
    .wr_en   (adr_wr_en),
    .wr_addr (adr_wr_addr),
    .wr_data (adr_wr_data)
  );

  tnc_scan #(
    .SW (SW)
  ) u_scan (
    .clk       (clk),
    .ctrl      (scan_ctrl),
    .idx       (ev_idx),
    .ent_valid (ent_rd_valid),
    .ent       (ent_rd_entry),
    .key       (cur.name_key),
    .now       (cur.now_ms),
    .flags     (scan_flags),
    .exp_idx   (exp_idx),
    .live_idx  (live_idx)
  );

  // Handshake helpers.
  assign item_stall = state != S_IDLE;
  assign accept = item_valid && !item_stall;
  assign out_free = !result_valid || !result_stall;
  assign is_store = cur.kind == tnc_pkg::KIND_STORE_ENTRY;
  assign done_last = ev_go && ev_idx == SW'(ENTRIES - 1);

  // Expiry of a new entry, saturating at the pinned value, and the clipped count.
  assign exp_sum = {1'b0, cur.now_ms} + {17'd0, ttl_ms};
  assign new_expiry = exp_sum[48] ? tnc_pkg::EXP_MAX : exp_sum[47:0];
  assign clip_count = (32'(cur.new_count) > MAX_ADDRS) ? CW'(MAX_ADDRS) : CW'(cur.new_count);
  assign addr_ok = current_ok && (32'(cur.addr_index) < MAX_ADDRS);

  // Memory write data comes straight from the held input word.
  assign ent_wr_entry = '{key: cur.name_key, expiry: new_expiry};
  assign adr_wr_data = '{high: cur.addr_high, low: cur.addr_low, is_v6: cur.addr_is_v6};
  assign adr_wr_addr = AW'(32'(current_slot) * MAX_ADDRS + 32'(cur.addr_index));
  assign adr_rd_addr = AW'(32'(hit_slot) * MAX_ADDRS + 32'(addr_k));
  assign ent_rd_addr = (state == S_CREAD) ? current_slot : issue_ptr[SW-1:0];

  // Sequencer.
  always_comb begin
    state_next = state;
    issue_ptr_next = issue_ptr;
    ev_go_next = 1'b0;
    ev_idx_next = ev_idx;
    hit_slot_next = hit_slot;
    hit_cnt_next = hit_cnt;
    addr_k_next = addr_k;
    pick_idx_next = pick_idx;
    res_hit_next = res_hit;
    res_slot_next = res_slot;
    res_cnt_next = res_cnt;
    current_slot_next = current_slot;
    current_ok_next = current_ok;
    hit_counter_next = hit_counter;
    miss_counter_next = miss_counter;
    result_valid_next = result_valid && result_stall;
    result_next = result;
    ent_rd_en = 1'b0;
    ent_wr_en = 1'b0;
    ent_clr = 1'b0;
    adr_rd_en = 1'b0;
    adr_wr_en = 1'b0;
    scan_ctrl = '{start: accept, step: 1'b0, is_store: is_store};

    case (state)
      S_IDLE: begin
        if (accept) begin
          issue_ptr_next = '0;
          case (item.kind)
            tnc_pkg::KIND_LOOKUP, tnc_pkg::KIND_STORE_ENTRY: begin
              state_next = S_SCAN;
            end
            tnc_pkg::KIND_STORE_ADDR: begin
              state_next = S_CREAD;
            end
            default: begin
              // Clear: drop all entries and counters at once.
              ent_clr = 1'b1;
              hit_counter_next = '0;
              miss_counter_next = '0;
              current_ok_next = 1'b0;
              res_hit_next = 1'b0;
              res_slot_next = '0;
              res_cnt_next = '0;
              state_next = S_EMIT;
            end
          endcase
        end
      end

      S_SCAN: begin
        // Issue the next entry read while the previous one is evaluated.
        if (issue_ptr < (SW + 1)'(ENTRIES)) begin
          ent_rd_en = 1'b1;
          ev_go_next = 1'b1;
          ev_idx_next = issue_ptr[SW-1:0];
          issue_ptr_next = issue_ptr + (SW + 1)'(1);
        end
        scan_ctrl.step = ev_go;
        if (ev_go && scan_flags.found) begin
          ev_go_next = 1'b0;
          if (is_store) begin
            pick_idx_next = ev_idx;
            state_next = S_WRITE;
          end else begin
            hit_slot_next = ev_idx;
            hit_cnt_next = ent_rd_count;
            hit_counter_next = hit_counter + 32'd1;
            addr_k_next = '0;
            if (ent_rd_count == '0) begin
              res_hit_next = 1'b1;
              res_slot_next = ev_idx;
              res_cnt_next = '0;
              state_next = S_EMIT;
            end else begin
              state_next = S_AREQ;
            end
          end
        end else if (done_last) begin
          ev_go_next = 1'b0;
          if (is_store) begin
            state_next = S_PICK;
          end else begin
            miss_counter_next = miss_counter + 32'd1;
            res_hit_next = 1'b0;
            res_slot_next = '0;
            res_cnt_next = '0;
            state_next = S_EMIT;
          end
        end
      end

      S_PICK: begin
        // Expired entries go first, then the live entry closest to expiry.
        if (scan_flags.exp_sel) begin
          pick_idx_next = exp_idx;
          state_next = S_WRITE;
        end else if (scan_flags.live_sel) begin
          pick_idx_next = live_idx;
          state_next = S_WRITE;
        end else begin
          current_ok_next = 1'b0;
          res_hit_next = 1'b0;
          res_slot_next = '0;
          res_cnt_next = '0;
          state_next = S_EMIT;
        end
      end

      S_WRITE: begin
        ent_wr_en = 1'b1;
        current_slot_next = pick_idx;
        current_ok_next = 1'b1;
        res_hit_next = 1'b1;
        res_slot_next = pick_idx;
        res_cnt_next = clip_count;
        state_next = S_EMIT;
      end

      S_CREAD: begin
        // Fetch the count of the slot that the last store entry wrote.
        ent_rd_en = 1'b1;
        state_next = S_CADDR;
      end

      S_CADDR: begin
        adr_wr_en = addr_ok;
        res_hit_next = addr_ok;
        res_slot_next = current_slot;
        res_cnt_next = ent_rd_count;
        state_next = S_EMIT;
      end

      S_AREQ: begin
        adr_rd_en = 1'b1;
        state_next = S_AOUT;
      end

      S_AOUT: begin
        if (out_free) begin
          result_valid_next = 1'b1;
          result_next.hit = 1'b1;
          result_next.slot = 4'(hit_slot);
          result_next.count_out = 4'(hit_cnt);
          result_next.out_high = adr_rd_data.high;
          result_next.out_low = adr_rd_data.low;
          result_next.out_is_v6 = adr_rd_data.is_v6;
          result_next.last = (addr_k + CW'(1)) == hit_cnt;
          result_next.hit_total = hit_counter;
          result_next.miss_total = miss_counter;
          if ((addr_k + CW'(1)) == hit_cnt) begin
            state_next = S_IDLE;
          end else begin
            addr_k_next = addr_k + CW'(1);
            state_next = S_AREQ;
          end
        end
      end

      S_EMIT: begin
        if (out_free) begin
          result_valid_next = 1'b1;
          result_next.hit = res_hit;
          result_next.slot = 4'(res_slot);
          result_next.count_out = 4'(res_cnt);
          result_next.out_high = '0;
          result_next.out_low = '0;
          result_next.out_is_v6 = 1'b0;
          result_next.last = 1'b1;
          result_next.hit_total = hit_counter;
          result_next.miss_total = miss_counter;
          state_next = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      ev_go <= 1'b0;
      current_slot <= '0;
      current_ok <= 1'b0;
      hit_counter <= '0;
      miss_counter <= '0;
      result_valid <= 1'b0;
      ttl_ms <= tnc_pkg::TTL_RESET;
    end else begin
      state <= state_next;
      ev_go <= ev_go_next;
      current_slot <= current_slot_next;
      current_ok <= current_ok_next;
      hit_counter <= hit_counter_next;
      miss_counter <= miss_counter_next;
      result_valid <= result_valid_next;
      if (ttl_we) begin
        ttl_ms <= ttl_wdata;
      end
    end
  end

  // Payload and working registers.
  always_ff @(posedge clk) begin
    if (accept) begin
      cur <= item;
    end
    issue_ptr <= issue_ptr_next;
    ev_idx <= ev_idx_next;
    hit_slot <= hit_slot_next;
    hit_cnt <= hit_cnt_next;
    addr_k <= addr_k_next;
    pick_idx <= pick_idx_next;
    res_hit <= res_hit_next;
    res_slot <= res_slot_next;
    res_cnt <= res_cnt_next;
    result <= result_next;
  end

  // An address read is only issued for a position below the hit entry's count.
  assert property (@(posedge clk) disable iff (rst)
    (state == S_AREQ) |-> (addr_k < hit_cnt))
    else $error("address read beyond the entry count");

  // The scan pointer never runs past the end of the entry table.
  assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN) |-> (issue_ptr <= (SW + 1)'(ENTRIES)))
    else $error("scan pointer out of range");

  // The miss counter only holds, steps by one, or returns to zero.
  assert property (@(posedge clk) disable iff (rst)
    !$past(rst) |-> (miss_counter == $past(miss_counter) ||
                     miss_counter == $past(miss_counter) + 32'd1 || miss_counter == '0))
    else $error("miss counter jumped");

  // A result that is not the last of its word is always a lookup hit.
  assert property (@(posedge clk) disable iff (rst)
    (result_valid && !result.last) |-> (result.hit && result.count_out != 4'd0))
    else $error("non-final result outside a lookup hit");

endmodule
